/* rtl/core/tmcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_pkg
// Shared types and constants of the tile map corner collision block.
// ----------------------------------------------------------------------------
package tmcc_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAP_COLUMNS = 1'b0;
   localparam logic REG_MAP_ROWS    = 1'b1;
   localparam logic [4:0] MAP_COLUMNS_RESET = 5'd16;
   localparam logic [4:0] MAP_ROWS_RESET    = 5'd16;
   localparam logic [4:0] MAX_COLUMNS       = 5'd16;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Flag bit positions
   localparam int FLAG_UL      = 1;
   localparam int FLAG_UR      = 2;
   localparam int FLAG_LR      = 3;
   localparam int FLAG_LL      = 4;
   localparam int FLAG_GROUND  = 5;
   localparam int FLAG_CEILING = 6;

   // Pixel rows probed per query, in read order
   localparam int PROBE_ABOVE  = 0;
   localparam int PROBE_TOP    = 1;
   localparam int PROBE_BOTTOM = 2;
   localparam int PROBE_BELOW  = 3;
   localparam int PROBES       = 4;

   typedef struct packed {
      logic [4:0] map_columns;
      logic [4:0] map_rows;
   } cfg_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_TOP,
      ST_RD_BOTTOM,
      ST_RD_BELOW,
      ST_FINISH,
      ST_HOLD
   } state_type;

endpackage

/* rtl/core/tmcc_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_req_if
// Command channel: map row writes and collision queries.
// ----------------------------------------------------------------------------
interface tmcc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [3:0] row_index;
   logic [15:0] row_bits;
   logic [7:0] pixel_x;
   logic [7:0] pixel_y;
   logic [7:0] sprite_width;
   logic [7:0] sprite_height;

   modport source (
      output valid, command, row_index, row_bits, pixel_x, pixel_y,
             sprite_width, sprite_height,
      input  ready
   );
   modport sink (
      input  valid, command, row_index, row_bits, pixel_x, pixel_y,
             sprite_width, sprite_height,
      output ready
   );
endinterface

/* rtl/core/tmcc_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_rsp_if
// Result channel: collision flags of one query.
// ----------------------------------------------------------------------------
interface tmcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] collision_flags;

   modport source (
      output valid, collision_flags,
      input  ready
   );
   modport sink (
      input  valid, collision_flags,
      output ready
   );
endinterface

/* rtl/core/tmcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tmcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/tmcc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_store
// Tile row store: RAM plus per-row valid bits, unwritten rows read as empty.
// ----------------------------------------------------------------------------
module tmcc_store #(
   parameter int MAX_ROWS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  tmcc_pkg::store_ctl_type                           ctl,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr,
   input  logic [15:0]                                       wr_data,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
   output logic [15:0]                                       rd_data
);
   logic [MAX_ROWS-1:0] valid_ff;
   logic [MAX_ROWS-1:0] valid_in;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [15:0]         ram_q;

   tmcc_ram #(
      .WIDTH (16),
      .DEPTH (MAX_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = ctl.rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Mask rows never written since reset
   assign rd_data = rd_valid_ff ? ram_q : 16'h0000;
endmodule

/* rtl/core/tmcc_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcc_csr
// Map size registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tmcc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tmcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tmcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tmcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output tmcc_pkg::cfg_type                   cfg
);
   logic [4:0] map_columns_ff;
   logic [4:0] map_columns_in;
   logic [4:0] map_rows_ff;
   logic [4:0] map_rows_in;
   logic       wr_hit;
   logic       reg_sel;

   assign reg_sel = csr_paddr[2];
   assign wr_hit  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      map_columns_in = map_columns_ff;
      map_rows_in    = map_rows_ff;
      if (wr_hit && reg_sel == tmcc_pkg::REG_MAP_COLUMNS) begin
         map_columns_in = csr_pwdata[4:0];
      end
      if (wr_hit && reg_sel == tmcc_pkg::REG_MAP_ROWS) begin
         map_rows_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff <= tmcc_pkg::MAP_COLUMNS_RESET;
         map_rows_ff    <= tmcc_pkg::MAP_ROWS_RESET;
      end else begin
         map_columns_ff <= map_columns_in;
         map_rows_ff    <= map_rows_in;
      end
   end

   always_comb begin
      case (reg_sel)
         tmcc_pkg::REG_MAP_COLUMNS: begin
            csr_prdata = {27'd0, map_columns_ff};
         end
         tmcc_pkg::REG_MAP_ROWS: begin
            csr_prdata = {27'd0, map_rows_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready      = 1'b1;
   assign cfg.map_columns = map_columns_ff;
   assign cfg.map_rows    = map_rows_ff;
endmodule

/* rtl/core/tile_map_corner_collision.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_corner_collision
// Tile map store with sprite corner, ground and ceiling collision queries.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries commands. A write beat (command 0) stores row_bits as
//   map row row_index and returns nothing. A query beat (command 1) returns
//   one rsp_chan beat with collision_flags. The tile store is a single RAM
//   with one read per cycle, so a query reads its four map rows (above the
//   sprite, top row, bottom row, below the sprite) one after another: idle,
//   RD_TOP, RD_BOTTOM and RD_BELOW issue the reads, and FINISH moves the
//   flags to the result register. The next command is taken only in idle,
//   so a query ends before the next starts; writes run one per cycle while idle.
//   The result register holds one finished beat; a stalled receiver lets
//   the next query run, whose flags then wait in the sequencer (req ready
//   low) until the result register frees up.
//   Reset clears the map (per-row valid bits), sets map_columns and
//   map_rows to 16 and drops any pending result.
//   The csr_ port holds map_columns at address 0 and map_rows at 4; write
//   it only while no query is in flight.
// ----------------------------------------------------------------------------
module tile_map_corner_collision #(
   parameter int MAX_ROWS    = 16,
   parameter int TILE_PIXELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   tmcc_req_if.sink                            req_chan,
   tmcc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tmcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tmcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tmcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   // Reciprocal for the pixel to tile division; exact for 8-bit pixels
   localparam int RECIP = (65536 + TILE_PIXELS - 1) / TILE_PIXELS;

   // Pixel to tile index: multiply by the reciprocal, keep the integer part
   function automatic logic [7:0] tile_of(input logic [7:0] pix);
      logic [24:0] prod;
      prod = 25'(pix) * 25'(RECIP);
      return prod[23:16];
   endfunction

   tmcc_pkg::cfg_type       cfg;
   tmcc_pkg::store_ctl_type store_ctl;
   tmcc_pkg::state_type     state_ff;
   tmcc_pkg::state_type     state_in;

   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [15:0]   row_q;

   // Effective map size
   logic [4:0] cols_eff;
   logic [5:0] rows_eff;

   // Query geometry computed at acceptance
   logic [7:0] xr;
   logic [7:0] yb;
   logic [7:0] below;
   logic [7:0] above;
   logic [7:0] tcx;
   logic [7:0] tcxr;
   logic [tmcc_pkg::PROBES-1:0][7:0] tr_in;
   logic [tmcc_pkg::PROBES-1:0][7:0] tr_ff;
   logic [tmcc_pkg::PROBES-1:0]      row_ok_in;
   logic [tmcc_pkg::PROBES-1:0]      row_ok_ff;
   logic       colx_ok_in;
   logic       colx_ok_ff;
   logic       colxr_ok_in;
   logic       colxr_ok_ff;
   logic [3:0] colx_bit_in;
   logic [3:0] colx_bit_ff;
   logic [3:0] colxr_bit_in;
   logic [3:0] colxr_bit_ff;

   // Sequencer controls
   logic       accept;
   logic       query_go;
   logic       capture;
   logic       result_ready;
   logic [1:0] probe_sel;
   logic       hit_l;
   logic       hit_r;
   logic [6:0] flags_ff;
   logic [6:0] flags_in;
   logic [6:0] flags_final;
   logic       slot_free;
   logic       load;

   // Result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [6:0] rsp_flags_ff;
   logic [6:0] rsp_flags_in;

   tmcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tmcc_store #(
      .MAX_ROWS (MAX_ROWS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_addr (wr_addr),
      .wr_data (req_chan.row_bits),
      .rd_addr (rd_addr),
      .rd_data (row_q)
   );

   // Clamp the register values to what the map can hold
   assign cols_eff = (cfg.map_columns > tmcc_pkg::MAX_COLUMNS) ?
                     tmcc_pkg::MAX_COLUMNS : cfg.map_columns;
   assign rows_eff = (6'(cfg.map_rows) > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : 6'(cfg.map_rows);

   // Corner and probe coordinates, all wrapping at 8 bits
   always_comb begin
      xr    = 8'(req_chan.pixel_x + req_chan.sprite_width + 8'hFF);
      yb    = 8'(req_chan.pixel_y + req_chan.sprite_height + 8'hFF);
      below = 8'(yb + 8'd1);
      above = 8'(req_chan.pixel_y + 8'hFF);
      tcx   = tile_of(req_chan.pixel_x);
      tcxr  = tile_of(xr);
      tr_in[tmcc_pkg::PROBE_ABOVE]  = tile_of(above);
      tr_in[tmcc_pkg::PROBE_TOP]    = tile_of(req_chan.pixel_y);
      tr_in[tmcc_pkg::PROBE_BOTTOM] = tile_of(yb);
      tr_in[tmcc_pkg::PROBE_BELOW]  = tile_of(below);
      for (int k = 0; k < tmcc_pkg::PROBES; k++) begin
         row_ok_in[k] = tr_in[k] < 8'(rows_eff);
      end
      // Columns are mirrored: column c sits in bit (cols - 1 - c)
      colx_ok_in   = tcx < 8'(cols_eff);
      colxr_ok_in  = tcxr < 8'(cols_eff);
      colx_bit_in  = 4'(cols_eff - 5'd1 - tcx[4:0]);
      colxr_bit_in = 4'(cols_eff - 5'd1 - tcxr[4:0]);
   end

   assign accept   = req_chan.valid & req_chan.ready;
   assign query_go = accept & (req_chan.command == tmcc_pkg::CMD_QUERY);
   assign wr_addr  = AW'(req_chan.row_index);

   // Hold query geometry for the read sequence
   always_ff @(posedge clock) begin
      if (query_go) begin
         tr_ff        <= tr_in;
         row_ok_ff    <= row_ok_in;
         colx_ok_ff   <= colx_ok_in;
         colxr_ok_ff  <= colxr_ok_in;
         colx_bit_ff  <= colx_bit_in;
         colxr_bit_ff <= colxr_bit_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmcc_pkg::ST_IDLE: begin
            if (query_go) begin
               state_in = tmcc_pkg::ST_RD_TOP;
            end
         end
         tmcc_pkg::ST_RD_TOP: begin
            state_in = tmcc_pkg::ST_RD_BOTTOM;
         end
         tmcc_pkg::ST_RD_BOTTOM: begin
            state_in = tmcc_pkg::ST_RD_BELOW;
         end
         tmcc_pkg::ST_RD_BELOW: begin
            state_in = tmcc_pkg::ST_FINISH;
         end
         tmcc_pkg::ST_FINISH: begin
            state_in = slot_free ? tmcc_pkg::ST_IDLE : tmcc_pkg::ST_HOLD;
         end
         tmcc_pkg::ST_HOLD: begin
            if (slot_free) begin
               state_in = tmcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmcc_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: one row read per cycle, each captured in the cycle after its read
   always_comb begin
      req_chan.ready  = 1'b0;
      store_ctl.wr_en = 1'b0;
      store_ctl.rd_en = 1'b0;
      rd_addr         = tr_in[tmcc_pkg::PROBE_ABOVE][AW-1:0];
      capture         = 1'b0;
      result_ready    = 1'b0;
      probe_sel       = 2'(tmcc_pkg::PROBE_ABOVE);
      case (state_ff)
         tmcc_pkg::ST_IDLE: begin
            // Hold off commands while reset is applied
            req_chan.ready  = ~reset;
            store_ctl.wr_en = req_chan.valid &
                              (req_chan.command == tmcc_pkg::CMD_WRITE) &
                              (32'(req_chan.row_index) < MAX_ROWS);
            store_ctl.rd_en = req_chan.valid &
                              (req_chan.command == tmcc_pkg::CMD_QUERY);
         end
         tmcc_pkg::ST_RD_TOP: begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = tr_ff[tmcc_pkg::PROBE_TOP][AW-1:0];
            capture         = 1'b1;
            probe_sel       = 2'(tmcc_pkg::PROBE_ABOVE);
         end
         tmcc_pkg::ST_RD_BOTTOM: begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = tr_ff[tmcc_pkg::PROBE_BOTTOM][AW-1:0];
            capture         = 1'b1;
            probe_sel       = 2'(tmcc_pkg::PROBE_TOP);
         end
         tmcc_pkg::ST_RD_BELOW: begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = tr_ff[tmcc_pkg::PROBE_BELOW][AW-1:0];
            capture         = 1'b1;
            probe_sel       = 2'(tmcc_pkg::PROBE_BOTTOM);
         end
         tmcc_pkg::ST_FINISH: begin
            capture      = 1'b1;
            result_ready = 1'b1;
            probe_sel    = 2'(tmcc_pkg::PROBE_BELOW);
         end
         tmcc_pkg::ST_HOLD: begin
            result_ready = 1'b1;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // Left and right corner tests on the row just read
   assign hit_l = capture & row_ok_ff[probe_sel] & colx_ok_ff & row_q[colx_bit_ff];
   assign hit_r = capture & row_ok_ff[probe_sel] & colxr_ok_ff & row_q[colxr_bit_ff];

   always_comb begin
      flags_final = flags_ff;
      case (probe_sel)
         2'(tmcc_pkg::PROBE_ABOVE): begin
            flags_final[tmcc_pkg::FLAG_CEILING] = flags_ff[tmcc_pkg::FLAG_CEILING] |
                                                  hit_l | hit_r;
         end
         2'(tmcc_pkg::PROBE_TOP): begin
            flags_final[tmcc_pkg::FLAG_UL] = flags_ff[tmcc_pkg::FLAG_UL] | hit_l;
            flags_final[tmcc_pkg::FLAG_UR] = flags_ff[tmcc_pkg::FLAG_UR] | hit_r;
         end
         2'(tmcc_pkg::PROBE_BOTTOM): begin
            flags_final[tmcc_pkg::FLAG_LL] = flags_ff[tmcc_pkg::FLAG_LL] | hit_l;
            flags_final[tmcc_pkg::FLAG_LR] = flags_ff[tmcc_pkg::FLAG_LR] | hit_r;
         end
         2'(tmcc_pkg::PROBE_BELOW): begin
            flags_final[tmcc_pkg::FLAG_GROUND] = flags_ff[tmcc_pkg::FLAG_GROUND] |
                                                 hit_l | hit_r;
         end
         default: begin
            flags_final = flags_ff;
         end
      endcase
      // Clear the accumulator when a query starts
      flags_in = query_go ? 7'd0 : flags_final;
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   // Result register: load when empty or being drained this cycle
   assign slot_free    = ~rsp_valid_ff | rsp_chan.ready;
   assign load         = result_ready & slot_free;
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_chan.ready);
   assign rsp_flags_in = load ? flags_final : rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.collision_flags = rsp_flags_ff;
endmodule
